// ----- rtl/lz4d_pkg.sv -----
// lz4d_pkg: shared types, codes and helpers of the lz4 block decompressor
// used by the parser, history, queue, top-level and checker files; depends on nothing
package lz4d_pkg;

  // item operations
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_COPY_BUSY  = 2'd1;
  localparam logic [1:0] ERR_BAD_OFFSET = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

  // format constants
  localparam logic [3:0] NIB_EXT   = 4'hF;
  localparam logic [7:0] BYTE_EXT  = 8'hFF;
  localparam logic [4:0] MATCH_MIN = 5'd4;

  // result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // per-item control record from the parser to the history stage
  typedef struct packed {
    logic        emit;
    logic        use_mem;
    logic [7:0]  lit_byte;
    logic        finish;
    logic        copy_pending;
    logic [31:0] count;
    logic [1:0]  err;
  } lz4d_item_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        data_valid;
    logic        end_of_block;
    logic        copy_pending;
    logic [31:0] out_count;
    logic [1:0]  error_code;
  } lz4d_result_t;

  // saturating length extension
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {25'd0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

// ----- rtl/lz4d_cmd_if.sv -----
// lz4d_cmd_if: input channel of the decompressor, valid/ready plus item fields
// depends on nothing
interface lz4d_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, output opcode, output in_byte, output in_last, input ready);
  modport sink(input valid, input opcode, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/lz4d_res_if.sv -----
// lz4d_res_if: result channel of the decompressor, valid/ready plus result fields
// depends on nothing
interface lz4d_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        data_valid;
  logic        end_of_block;
  logic        copy_pending;
  logic [31:0] out_count;
  logic [1:0]  error_code;

  modport source(output valid, output out_byte, output data_valid, output end_of_block,
                 output copy_pending, output out_count, output error_code, input ready);
  modport sink(input valid, input out_byte, input data_valid, input end_of_block,
               input copy_pending, input out_count, input error_code, output ready);
endinterface

// ----- rtl/lz4d_parse.sv -----
// lz4d_parse: token/length/offset parser, block counters and history addressing
// depends on lz4d_pkg
module lz4d_parse
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          opcode,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output lz4d_item_t    item,
  output logic [AW-1:0] raddr,
  output logic [AW-1:0] waddr
);

  typedef enum logic [2:0] {
    PH_TOKEN    = 3'd0,
    PH_LITEXT   = 3'd1,
    PH_LITERALS = 3'd2,
    PH_OFFLO    = 3'd3,
    PH_OFFHI    = 3'd4,
    PH_MATEXT   = 3'd5,
    PH_COPY     = 3'd6
  } phase_t;

  phase_t        phase, phase_next;
  logic [3:0]    match_nibble, match_nibble_next;
  logic [31:0]   lit_rem, lit_rem_next;
  logic [31:0]   mat_rem, mat_rem_next;
  logic [15:0]   match_offset, match_offset_next;
  logic [AW-1:0] wp, wp_next;
  logic [31:0]   produced, produced_next;
  logic          end_pending, end_pending_next;

  logic          emit, use_mem, finish;
  logic [7:0]    lit_byte;
  logic [1:0]    err;
  logic [31:0]   lit_dec, mat_dec, mat_ext;
  logic [15:0]   off_full;
  logic          off_bad;
  logic [16:0]   wp17, off17, idx17;

  // decrements and offset check
  assign lit_dec  = (lit_rem != 32'd0) ? lit_rem - 32'd1 : lit_rem;
  assign mat_dec  = (mat_rem != 32'd0) ? mat_rem - 32'd1 : mat_rem;
  assign mat_ext  = sat_add(mat_rem, in_byte);
  assign off_full = {in_byte, match_offset[7:0]};
  assign off_bad  = (off_full == 16'd0) || ({16'd0, off_full} > produced) ||
                    ({1'b0, off_full} > 17'(WINDOW_BYTES));

  // history read address, one offset behind the write pointer with wrap
  assign wp17  = 17'(wp);
  assign off17 = {1'b0, match_offset};
  assign idx17 = (wp17 >= off17) ? wp17 - off17 : wp17 + 17'(WINDOW_BYTES) - off17;
  assign raddr = idx17[AW-1:0];
  assign waddr = wp;

  // next state of the parser for the item at the port
  always_comb begin
    phase_next        = phase;
    match_nibble_next = match_nibble;
    lit_rem_next      = lit_rem;
    mat_rem_next      = mat_rem;
    match_offset_next = match_offset;
    end_pending_next  = end_pending;
    emit              = 1'b0;
    use_mem           = 1'b0;
    lit_byte          = 8'd0;
    finish            = 1'b0;
    err               = ERR_NONE;
    if (opcode == OP_ADVANCE) begin
      if (phase == PH_COPY) begin
        emit         = 1'b1;
        use_mem      = (match_offset != 16'd0);
        err          = (match_offset == 16'd0) ? ERR_BAD_OFFSET : ERR_NONE;
        mat_rem_next = mat_dec;
        if (mat_dec == 32'd0) begin
          if (end_pending) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end
    end else begin
      unique case (phase)
        PH_TOKEN: begin
          match_nibble_next = in_byte[3:0];
          lit_rem_next      = {28'd0, in_byte[7:4]};
          if (in_byte[7:4] == NIB_EXT) begin
            phase_next = PH_LITEXT;
          end else if (in_byte[7:4] != 4'd0) begin
            phase_next = PH_LITERALS;
          end else begin
            phase_next = PH_OFFLO;
          end
          if (in_last) begin
            finish = 1'b1;
            err    = (in_byte[7:4] != 4'd0) ? ERR_TRUNCATED : ERR_NONE;
          end
        end
        PH_LITEXT: begin
          lit_rem_next = sat_add(lit_rem, in_byte);
          if (in_byte != BYTE_EXT) begin
            phase_next = PH_LITERALS;
          end
          if (in_last) begin
            finish = 1'b1;
            err    = ERR_TRUNCATED;
          end
        end
        PH_LITERALS: begin
          emit         = 1'b1;
          lit_byte     = in_byte;
          lit_rem_next = lit_dec;
          if (lit_dec == 32'd0) begin
            phase_next = PH_OFFLO;
          end
          if (in_last) begin
            finish = 1'b1;
            err    = (lit_dec != 32'd0) ? ERR_TRUNCATED : ERR_NONE;
          end
        end
        PH_OFFLO: begin
          match_offset_next = {8'd0, in_byte};
          phase_next        = PH_OFFHI;
          if (in_last) begin
            finish = 1'b1;
            err    = ERR_TRUNCATED;
          end
        end
        PH_OFFHI: begin
          match_offset_next = off_bad ? 16'd0 : off_full;
          mat_rem_next      = {27'd0, {1'b0, match_nibble} + MATCH_MIN};
          phase_next        = (match_nibble == NIB_EXT) ? PH_MATEXT : PH_COPY;
          if (in_last) begin
            if (match_nibble != NIB_EXT) begin
              end_pending_next = 1'b1;
            end else begin
              finish = 1'b1;
              err    = ERR_TRUNCATED;
            end
          end
        end
        PH_MATEXT: begin
          mat_rem_next = mat_ext;
          if (in_byte != BYTE_EXT) begin
            phase_next = PH_COPY;
          end
          if (in_last) begin
            if (in_byte != BYTE_EXT) begin
              end_pending_next = 1'b1;
            end else begin
              finish = 1'b1;
              err    = ERR_TRUNCATED;
            end
          end
        end
        PH_COPY: begin
          err = ERR_COPY_BUSY;
        end
        default: begin
          phase_next = PH_TOKEN;
        end
      endcase
    end
  end

  // write pointer and byte count advance on every emitted byte
  always_comb begin
    wp_next       = wp;
    produced_next = produced + {31'd0, emit};
    if (emit) begin
      wp_next = (wp == AW'(WINDOW_BYTES - 1)) ? '0 : wp + AW'(1);
    end
  end

  // control record for the history stage
  always_comb begin
    item.emit         = emit;
    item.use_mem      = use_mem;
    item.lit_byte     = lit_byte;
    item.finish       = finish;
    item.copy_pending = !finish && (phase_next == PH_COPY);
    item.count        = produced_next;
    item.err          = err;
  end

  // parser state; end of block returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (accept && finish)) begin
      phase        <= PH_TOKEN;
      match_nibble <= 4'd0;
      lit_rem      <= 32'd0;
      mat_rem      <= 32'd0;
      match_offset <= 16'd0;
      wp           <= '0;
      produced     <= 32'd0;
      end_pending  <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      match_nibble <= match_nibble_next;
      lit_rem      <= lit_rem_next;
      mat_rem      <= mat_rem_next;
      match_offset <= match_offset_next;
      wp           <= wp_next;
      produced     <= produced_next;
      end_pending  <= end_pending_next;
    end
  end

endmodule

// ----- rtl/lz4d_hist.sv -----
// lz4d_hist: history memory with read-modify-write and forwarding of the last write
// depends on lz4d_pkg
module lz4d_hist
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  lz4d_item_t    item,
  input  logic [AW-1:0] raddr,
  input  logic [AW-1:0] waddr,
  output logic          res_valid,
  output lz4d_result_t  res
);

  logic [7:0]    mem [WINDOW_BYTES];
  logic [7:0]    rdata;
  logic          s1_valid;
  lz4d_item_t    s1_item;
  logic [AW-1:0] s1_waddr;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;
  logic [7:0]    s1_byte;

  // byte of the item in flight: literal, history read or forwarded write
  always_comb begin
    if (!s1_item.emit) begin
      s1_byte = 8'd0;
    end else if (!s1_item.use_mem) begin
      s1_byte = s1_item.lit_byte;
    end else if (s1_fwd) begin
      s1_byte = s1_fwd_data;
    end else begin
      s1_byte = rdata;
    end
  end

  // history memory: read for the new item, write back the emitted byte
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[raddr];
    end
    if (s1_valid && s1_item.emit) begin
      mem[s1_waddr] <= s1_byte;
    end
  end

  // stage register; forward when the read hits the byte written this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_item     <= item;
    s1_waddr    <= waddr;
    s1_fwd      <= s1_valid && s1_item.emit && (s1_waddr == raddr);
    s1_fwd_data <= s1_byte;
  end

  assign res_valid = s1_valid;

  always_comb begin
    res.out_byte     = s1_byte;
    res.data_valid   = s1_item.emit;
    res.end_of_block = s1_item.finish;
    res.copy_pending = s1_item.copy_pending;
    res.out_count    = s1_item.count;
    res.error_code   = s1_item.err;
  end

endmodule

// ----- rtl/lz4d_out_q.sv -----
// lz4d_out_q: small result queue that decouples the pipeline from output stalls
// depends on lz4d_pkg and lz4d_res_if
module lz4d_out_q
  import lz4d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lz4d_result_t  push_data,
  output logic [QAW:0]  count,
  lz4d_res_if.source    res
);

  lz4d_result_t   q [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic           pop;

  assign pop = res.valid && res.ready;

  // storage and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  // head of the queue drives the port
  assign res.valid        = (count != '0);
  assign res.out_byte     = q[rd_ptr].out_byte;
  assign res.data_valid   = q[rd_ptr].data_valid;
  assign res.end_of_block = q[rd_ptr].end_of_block;
  assign res.copy_pending = q[rd_ptr].copy_pending;
  assign res.out_count    = q[rd_ptr].out_count;
  assign res.error_code   = q[rd_ptr].error_code;

endmodule

// ----- rtl/lz4_block_decompressor.sv -----
// lz4_block_decompressor: raw lz4 block decoder, one byte or copy step per transfer
// each result is registered in the history stage and then in the result queue before it can transfer
// throughput: one item per cycle; input stalls while the history stage and the four-entry result queue hold four
// results together; short offsets are served by forwarding the byte written in the same cycle
// reset: synchronous, clears parser state, counters and the result queue;
// the history memory is not cleared, bytes are read only after being written
module lz4_block_decompressor
  import lz4d_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst,
  lz4d_cmd_if.sink   cmd,
  lz4d_res_if.source res
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  lz4d_item_t    item;
  lz4d_result_t  stage_res;
  logic [AW-1:0] raddr, waddr;
  logic          accept;
  logic          stage_valid;
  logic [QAW:0]  q_count;

  // accept only when the queue can hold everything in flight
  assign cmd.ready = (({{QAW{1'b0}}, stage_valid} + q_count) < (QAW + 1)'(QDEPTH));
  assign accept    = cmd.valid && cmd.ready;

  lz4d_parse #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .AW(AW)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .opcode(cmd.opcode),
    .in_byte(cmd.in_byte),
    .in_last(cmd.in_last),
    .item(item),
    .raddr(raddr),
    .waddr(waddr)
  );

  lz4d_hist #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .AW(AW)
  ) u_hist (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .raddr(raddr),
    .waddr(waddr),
    .res_valid(stage_valid),
    .res(stage_res)
  );

  lz4d_out_q u_out_q (
    .clk(clk),
    .rst(rst),
    .push(stage_valid),
    .push_data(stage_res),
    .count(q_count),
    .res(res)
  );

endmodule

// ----- rtl/lz4d_checker.sv -----
// lz4d_checker: port-level assertions for the lz4 block decompressor, with its bind
// depends on lz4d_pkg and lz4_block_decompressor
module lz4d_checker
  import lz4d_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  out_byte,
  input logic        data_valid,
  input logic        end_of_block,
  input logic        copy_pending,
  input logic [31:0] out_count,
  input logic [1:0]  error_code
);

  // a bad-offset copy still emits a byte, and that byte is zero
  a_bad_offset_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (error_code == ERR_BAD_OFFSET) |-> data_valid && (out_byte == 8'd0))
    else $error("bad offset result without a zero data byte");

  // the block's closing result never announces more copy work
  a_end_no_copy: assert property (@(posedge clk) disable iff (rst)
    res_valid && end_of_block |-> !copy_pending)
    else $error("end of block with copy still pending");

  // a byte fed during a copy emits no data and does not end the block
  a_busy_ignored: assert property (@(posedge clk) disable iff (rst)
    res_valid && (error_code == ERR_COPY_BUSY) |-> !data_valid && !end_of_block)
    else $error("byte fed during copy produced data or ended the block");

  // a stalled result transfer holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(data_valid) &&
      $stable(end_of_block) && $stable(copy_pending) && $stable(out_count) &&
      $stable(error_code))
    else $error("result changed while stalled");

endmodule

bind lz4_block_decompressor lz4d_checker u_lz4d_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .out_byte(res.out_byte),
  .data_valid(res.data_valid),
  .end_of_block(res.end_of_block),
  .copy_pending(res.copy_pending),
  .out_count(res.out_count),
  .error_code(res.error_code)
);

// ----- tb/tb_lz4_block_decompressor.sv -----
`timescale 1ns / 100ps
// tb_lz4_block_decompressor: drives compressed bytes and copy steps into the lz4 block decoder
// and checks every result against a decoder model kept in the bench
// depends on lz4d_pkg, lz4d_cmd_if, lz4d_res_if and lz4_block_decompressor
module tb_lz4_block_decompressor;
  import lz4d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [2:0] {
    ST_TOKEN, ST_LIT_EXT, ST_LITERALS, ST_OFF_LO, ST_OFF_HI, ST_MATCH_EXT, ST_COPY
  } dec_state_t;

  typedef enum logic [1:0] {END_MORE, END_LITERALS, END_AFTER_MATCH, END_TRUNCATE} seq_end_t;

  logic clk;
  logic rst;

  lz4d_cmd_if cmd_ch ();
  lz4d_res_if res_ch ();

  lz4_block_decompressor dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // decoder model state
  dec_state_t  ph;
  logic [3:0]  m_nib;
  logic [31:0] lit_left;
  logic [31:0] match_left;
  logic [15:0] m_off;
  logic [15:0] wr_ptr;
  logic [31:0] byte_total;
  logic        stop_after_copy;
  logic [7:0]  window_mem [0:65535];

  lz4d_result_t decoder_results_q [$];
  int unsigned  useful_items;
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  bit           tx_gaps_on;
  bit           rx_gaps_on;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lz4_block_decompressor test failed");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // saturating length extension
  function automatic logic [31:0] extend_len(input logic [31:0] len, input logic [7:0] add);
    logic [32:0] sum;
    sum = {1'b0, len} + {25'd0, add};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void clear_block_state();
    ph              = ST_TOKEN;
    m_nib           = 4'd0;
    lit_left        = 32'd0;
    match_left      = 32'd0;
    m_off           = 16'd0;
    wr_ptr          = 16'd0;
    byte_total      = 32'd0;
    stop_after_copy = 1'b0;
  endfunction

  // advance the decoder model by one item and return the result it produces
  function automatic lz4d_result_t decode_step(input logic op, input logic [7:0] data,
                                               input logic last);
    lz4d_result_t r;
    logic         done;
    logic [15:0]  back_ref;
    r    = '0;
    done = 1'b0;
    if (op == OP_ADVANCE) begin
      // one match byte per advance, advances outside a copy are dropped
      if (ph == ST_COPY) begin
        if (m_off == 16'd0) begin
          r.error_code = ERR_BAD_OFFSET;
        end else begin
          back_ref   = wr_ptr - m_off;
          r.out_byte = window_mem[back_ref];
        end
        r.data_valid       = 1'b1;
        window_mem[wr_ptr] = r.out_byte;
        wr_ptr             = wr_ptr + 16'd1;
        byte_total         = byte_total + 32'd1;
        if (match_left != 32'd0) match_left = match_left - 32'd1;
        if (match_left == 32'd0) begin
          if (stop_after_copy) done = 1'b1;
          else ph = ST_TOKEN;
        end
      end
    end else begin
      case (ph)
        ST_TOKEN: begin
          m_nib    = data[3:0];
          lit_left = {28'd0, data[7:4]};
          if (data[7:4] == NIB_EXT) ph = ST_LIT_EXT;
          else if (data[7:4] != 4'd0) ph = ST_LITERALS;
          else ph = ST_OFF_LO;
          if (last) begin
            done = 1'b1;
            if (data[7:4] != 4'd0) r.error_code = ERR_TRUNCATED;
          end
        end
        ST_LIT_EXT: begin
          lit_left = extend_len(lit_left, data);
          if (data != BYTE_EXT) ph = ST_LITERALS;
          if (last) begin
            done         = 1'b1;
            r.error_code = ERR_TRUNCATED;
          end
        end
        ST_LITERALS: begin
          r.out_byte         = data;
          r.data_valid       = 1'b1;
          window_mem[wr_ptr] = data;
          wr_ptr             = wr_ptr + 16'd1;
          byte_total         = byte_total + 32'd1;
          if (lit_left != 32'd0) lit_left = lit_left - 32'd1;
          if (lit_left == 32'd0) ph = ST_OFF_LO;
          if (last) begin
            done = 1'b1;
            if (lit_left != 32'd0) r.error_code = ERR_TRUNCATED;
          end
        end
        ST_OFF_LO: begin
          m_off = {8'd0, data};
          ph    = ST_OFF_HI;
          if (last) begin
            done         = 1'b1;
            r.error_code = ERR_TRUNCATED;
          end
        end
        ST_OFF_HI: begin
          // a zero offset or one past the bytes produced turns into a zero-fill copy
          back_ref = {data, m_off[7:0]};
          if ({16'd0, back_ref} > byte_total) back_ref = 16'd0;
          m_off      = back_ref;
          match_left = {28'd0, m_nib} + 32'(MATCH_MIN);
          ph         = (m_nib == NIB_EXT) ? ST_MATCH_EXT : ST_COPY;
          if (last) begin
            if (ph == ST_COPY) begin
              stop_after_copy = 1'b1;
            end else begin
              done         = 1'b1;
              r.error_code = ERR_TRUNCATED;
            end
          end
        end
        ST_MATCH_EXT: begin
          match_left = extend_len(match_left, data);
          if (data != BYTE_EXT) ph = ST_COPY;
          if (last) begin
            if (ph == ST_COPY) begin
              stop_after_copy = 1'b1;
            end else begin
              done         = 1'b1;
              r.error_code = ERR_TRUNCATED;
            end
          end
        end
        ST_COPY: begin
          r.error_code = ERR_COPY_BUSY;
        end
        default: begin
          ph = ST_TOKEN;
        end
      endcase
    end
    r.end_of_block = done;
    r.copy_pending = !done && (ph == ST_COPY);
    r.out_count    = byte_total;
    if (done) clear_block_state();
    return r;
  endfunction

  // one input transfer, with an optional gap before it
  task automatic send_item(input logic op, input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = pick_gap(tx_gaps_on);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.in_byte <= data;
    cmd_ch.in_last <= last;
    do @(posedge clk); while (!cmd_ch.ready);
    if ((op == OP_FEED && ph != ST_COPY) || (op == OP_ADVANCE && ph == ST_COPY))
      useful_items++;
    decoder_results_q.push_back(decode_step(op, data, last));
    @(negedge clk);
  endtask

  // hold the input until every expected result has come back
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (decoder_results_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one block of random sequences, mostly well formed, ending in one of the legal ways
  // or cut short
  task automatic send_random_block();
    logic [7:0]  seq_q [$];
    int unsigned nseq;
    int unsigned lit_len;
    int unsigned mlen;
    int unsigned rem;
    int unsigned avail;
    int unsigned r;
    int          stop_at;
    logic [3:0]  mnib;
    logic [15:0] off;
    seq_end_t    ending;
    nseq = $urandom_range(1, 6);
    for (int s = 0; s < nseq; s++) begin
      // lengths: mostly short, some extended, a few long
      r = $urandom_range(0, 99);
      if (r < 70) lit_len = $urandom_range(0, 14);
      else if (r < 92) lit_len = $urandom_range(15, 40);
      else lit_len = $urandom_range(15, 600);
      r = $urandom_range(0, 99);
      if (r < 75) mlen = $urandom_range(4, 18);
      else if (r < 93) mlen = $urandom_range(19, 60);
      else mlen = $urandom_range(19, 400);

      ending = END_MORE;
      if (s == nseq - 1) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          ending = END_LITERALS;
          if (r < 12) lit_len = 0;
        end else if (r < 70) begin
          ending = END_AFTER_MATCH;
        end else begin
          ending = END_TRUNCATE;
        end
      end

      // offset: many short ones, the rest anywhere back, some zero or past the output
      avail = byte_total + lit_len;
      r     = $urandom_range(0, 99);
      if (r < 8 || avail == 0) off = 16'd0;
      else if (r < 18) off = (avail >= 65535) ? 16'hFFFF : 16'($urandom_range(avail + 1, 65535));
      else if (r < 55) off = 16'($urandom_range(1, (avail < 4) ? avail : 4));
      else off = 16'($urandom_range(1, (avail < 65535) ? avail : 65535));

      // token, literal extension, literals, offset, match extension
      seq_q.delete();
      mnib = (mlen >= 19) ? NIB_EXT : 4'(mlen - 4);
      if (ending == END_LITERALS) mnib = 4'($urandom_range(0, 15));
      seq_q.push_back({(lit_len >= 15) ? NIB_EXT : 4'(lit_len), mnib});
      if (lit_len >= 15) begin
        rem = lit_len - 15;
        while (rem >= 255) begin
          seq_q.push_back(BYTE_EXT);
          rem -= 255;
        end
        seq_q.push_back(8'(rem));
      end
      repeat (lit_len) seq_q.push_back(8'($urandom_range(0, 255)));
      if (ending != END_LITERALS) begin
        seq_q.push_back(off[7:0]);
        seq_q.push_back(off[15:8]);
        if (mnib == NIB_EXT) begin
          rem = mlen - 19;
          while (rem >= 255) begin
            seq_q.push_back(BYTE_EXT);
            rem -= 255;
          end
          seq_q.push_back(8'(rem));
        end
      end

      stop_at = seq_q.size() - 1;
      if (ending == END_TRUNCATE) stop_at = $urandom_range(0, seq_q.size() - 1);
      for (int i = 0; i <= stop_at; i++) begin
        // a stray advance while parsing is dropped by the block
        if ($urandom_range(0, 49) == 0) send_item(OP_ADVANCE, 8'($urandom), 1'($urandom));
        send_item(OP_FEED, seq_q[i], (ending != END_MORE) && (i == stop_at));
      end

      // copy out the match, with a stray byte now and then
      while (ph == ST_COPY) begin
        if ($urandom_range(0, 19) == 0) send_item(OP_FEED, 8'($urandom), 1'($urandom));
        else send_item(OP_ADVANCE, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_literals_and_copy();
    // two literals at the byte extremes, offset 2, four byte match
    send_item(OP_FEED, 8'h20, 1'b0);
    send_item(OP_FEED, 8'h00, 1'b0);
    send_item(OP_FEED, 8'hFF, 1'b0);
    send_item(OP_FEED, 8'h02, 1'b0);
    send_item(OP_FEED, 8'h00, 1'b0);
    send_item(OP_ADVANCE, 8'h00, 1'b0);
    // a byte during the copy is dropped, its last flag too
    send_item(OP_FEED, 8'h5A, 1'b1);
    repeat (3) send_item(OP_ADVANCE, 8'hFF, 1'b1);
  endtask

  task automatic test_idle_advance();
    send_item(OP_ADVANCE, 8'hFF, 1'b1);
  endtask

  task automatic test_bad_offset_end_on_match();
    // offset past the bytes produced, block ends once the zero-fill copy is done
    send_item(OP_FEED, 8'h00, 1'b0);
    send_item(OP_FEED, 8'h40, 1'b0);
    send_item(OP_FEED, 8'h00, 1'b1);
    repeat (4) send_item(OP_ADVANCE, 8'h00, 1'b0);
  endtask

  task automatic test_short_endings();
    // empty final literals end cleanly
    send_item(OP_FEED, 8'h0F, 1'b1);
    // cut short on a token with literals and inside a literal extension
    send_item(OP_FEED, 8'hF0, 1'b1);
    send_item(OP_FEED, 8'hF0, 1'b0);
    send_item(OP_FEED, 8'hFF, 1'b1);
  endtask

  task automatic test_drained_restart();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    send_random_block();
    wait_drained();
    send_random_block();
    wait_drained();
  endtask

  task automatic test_random_blocks();
    while (useful_items < 1000) begin
      // idling on or off per block so some stretches run back to back
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      send_random_block();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left   <= pick_gap(rx_gaps_on);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // compare each result transfer with the oldest expected result
  always @(posedge clk) begin : result_check
    lz4d_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (decoder_results_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        error_count++;
      end else begin
        want = decoder_results_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(res_ch.out_byte));
        check_field("data_valid", 32'(want.data_valid), 32'(res_ch.data_valid));
        check_field("end_of_block", 32'(want.end_of_block), 32'(res_ch.end_of_block));
        check_field("copy_pending", 32'(want.copy_pending), 32'(res_ch.copy_pending));
        check_field("out_count", want.out_count, res_ch.out_count);
        check_field("error_code", 32'(want.error_code), 32'(res_ch.error_code));
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = OP_FEED;
    cmd_ch.in_byte = 8'd0;
    cmd_ch.in_last = 1'b0;
    res_ch.ready   = 1'b0;
    useful_items   = 0;
    error_count    = 0;
    cycle_count    = 0;
    stall_left     = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    clear_block_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_literals_and_copy();
    test_idle_advance();
    test_bad_offset_end_on_match();
    test_short_endings();
    test_drained_restart();
    test_random_blocks();

    // let the last results out, then watch for strays
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && decoder_results_q.size() == 0) begin
      $display("lz4_block_decompressor test passed");
    end else begin
      $display("lz4_block_decompressor test failed");
    end
    $finish;
  end

endmodule

// ----- lz4_block_decompressor.f -----
rtl/lz4d_pkg.sv
rtl/lz4d_cmd_if.sv
rtl/lz4d_res_if.sv
rtl/lz4d_parse.sv
rtl/lz4d_hist.sv
rtl/lz4d_out_q.sv
rtl/lz4_block_decompressor.sv
rtl/lz4d_checker.sv
tb/tb_lz4_block_decompressor.sv
